>>> hw/rtl/scpd_pkg.sv
// shared types and constants for the sparse colour presence detector
// depends on nothing; used by every other file of the block but scpd_ifs
`default_nettype none

package scpd_pkg;

  localparam int unsigned DEF_FACTOR_FRACTION_BITS = 24;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned SPAN_W     = 32;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned WAB_W      = 48;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned BOUND_W    = 32;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned AREA_W     = 32;
  localparam int unsigned SQ_W       = 2 * CHAN_W;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_COLOR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUE_FACTOR   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAT_FACTOR   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VAL_FACTOR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_X     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_Y     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_BOUND = 3'd7;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
    logic emit_value;
    logic finish;
  } scpd_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sample_due;
    logic hit;
    logic miss;
    logic out_full;
    logic decided;
    logic frame_end;
  } scpd_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/scpd_ifs.sv
// valid/ready channel interfaces for pixel beats and result beats
// depends on nothing
`default_nettype none

interface scpd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_hue;
  logic [7:0] pixel_sat;
  logic [7:0] pixel_val;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, pixel_hue, pixel_sat, pixel_val, row_end, frame_end,
                  input ready);
  modport sink (input valid, pixel_hue, pixel_sat, pixel_val, row_end, frame_end,
                output ready);
endinterface

interface scpd_result_if;
  logic        valid;
  logic        ready;
  logic        is_color;
  logic [31:0] matched_weight;

  modport source (output valid, is_color, matched_weight, input ready);
  modport sink (input valid, is_color, matched_weight, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/scpd_divider.sv
// restoring divider, one quotient bit per cycle, for the sample step
// depends on scpd_pkg
`default_nettype none

module scpd_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [scpd_pkg::AREA_W-1:0]   dividend,
  input  wire logic [scpd_pkg::COUNT_W-1:0]  divisor,
  output logic                               busy,
  output logic [scpd_pkg::AREA_W-1:0]        quotient
);
  import scpd_pkg::*;

  localparam int unsigned ITER_W = $clog2(AREA_W);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(AREA_W - 1);

  logic [ITER_W-1:0]  iter;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] div_r;
  logic [COUNT_W:0]   shifted;
  logic [COUNT_W:0]   trial;
  logic               take;

  assign shifted = {rem, quotient[AREA_W-1]};
  assign trial   = shifted - {1'b0, div_r};
  assign take    = shifted >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      quotient <= '0;
      iter     <= '0;
    end else if (start) begin
      iter  <= '0;
      div_r <= divisor;
      rem   <= '0;
      if (divisor == '0) begin
        quotient <= '0;
        busy     <= 1'b0;
      end else begin
        quotient <= dividend;
        busy     <= 1'b1;
      end
    end else if (busy) begin
      rem      <= take ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quotient <= {quotient[AREA_W-2:0], take};
      iter     <= iter + 1'b1;
      if (iter == LAST_ITER) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scpd_datapath.sv
// datapath: configuration registers, colour error pipeline, frame counters,
// sample bookkeeping and the result register; depends on scpd_pkg, scpd_divider
`default_nettype none

module scpd_datapath #(
  parameter int unsigned FACTOR_FRACTION_BITS = scpd_pkg::DEF_FACTOR_FRACTION_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [scpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [scpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [7:0]                       pixel_hue,
  input  wire logic [7:0]                       pixel_sat,
  input  wire logic [7:0]                       pixel_val,
  input  wire logic                             row_end,
  input  wire logic                             frame_end,
  input  wire scpd_pkg::scpd_cmd_t              cmd,
  output scpd_pkg::scpd_status_t                status,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output logic                                  res_is_color,
  output logic [31:0]                           res_weight
);
  import scpd_pkg::*;

  localparam int unsigned FACTOR_W = FACTOR_FRACTION_BITS + 1;
  localparam int unsigned PROD_W   = FACTOR_W + SQ_W;
  localparam int unsigned ERR_W    = PROD_W + 2;
  localparam logic [ERR_W-1:0] ERR_LIMIT = ERR_W'(1) << FACTOR_FRACTION_BITS;

  // configuration
  logic [COLOR_W-1:0]  target_color;
  logic [FACTOR_W-1:0] hue_factor;
  logic [FACTOR_W-1:0] sat_factor;
  logic [FACTOR_W-1:0] val_factor;
  logic [SPAN_W-1:0]   region_x_span;
  logic [SPAN_W-1:0]   region_y_span;
  logic [COUNT_W-1:0]  sample_count;
  logic [WAB_W-1:0]    weight_and_boundary;

  // step derivation
  logic                start_pending;
  logic                div_busy;
  logic [AREA_W-1:0]   sample_step;
  logic [COORD_W-1:0]  x_len;
  logic [COORD_W-1:0]  y_len;
  logic [AREA_W-1:0]   area;

  // pixel and error pipeline
  logic [CHAN_W-1:0]   hue_r;
  logic [CHAN_W-1:0]   sat_r;
  logic [CHAN_W-1:0]   val_r;
  logic                row_end_r;
  logic                frame_end_r;
  logic [SQ_W-1:0]     hue_sq;
  logic [SQ_W-1:0]     sat_sq;
  logic [SQ_W-1:0]     val_sq;
  logic [PROD_W-1:0]   hue_prod;
  logic [PROD_W-1:0]   sat_prod;
  logic [PROD_W-1:0]   val_prod;
  logic [ERR_W-1:0]    err_sum;
  logic                match;

  // per-frame state
  logic [COORD_W-1:0]  column_counter;
  logic [COORD_W-1:0]  row_counter;
  logic [OFFSET_W-1:0] region_offset;
  logic [OFFSET_W-1:0] next_sample_offset;
  logic [COUNT_W-1:0]  samples_seen;
  logic [BOUND_W-1:0]  weight_sum;
  logic                decided_flag;

  logic [WEIGHT_W-1:0] weight;
  logic [BOUND_W-1:0]  boundary;
  logic                in_region;
  logic [COUNT_W-1:0]  left;
  logic [BOUND_W-1:0]  reach;

  function automatic logic [COORD_W-1:0] span_len(input logic [SPAN_W-1:0] span);
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    lo = span[COORD_W-1:0];
    hi = span[SPAN_W-1:COORD_W];
    return (hi > lo) ? hi - lo : '0;
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      target_color        <= '0;
      hue_factor          <= '0;
      sat_factor          <= '0;
      val_factor          <= '0;
      region_x_span       <= '0;
      region_y_span       <= '0;
      sample_count        <= COUNT_W'(1);
      weight_and_boundary <= WAB_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TARGET_COLOR: target_color        <= cfg_data[COLOR_W-1:0];
        CFG_HUE_FACTOR:   hue_factor          <= cfg_data[FACTOR_W-1:0];
        CFG_SAT_FACTOR:   sat_factor          <= cfg_data[FACTOR_W-1:0];
        CFG_VAL_FACTOR:   val_factor          <= cfg_data[FACTOR_W-1:0];
        CFG_REGION_X:     region_x_span       <= cfg_data[SPAN_W-1:0];
        CFG_REGION_Y:     region_y_span       <= cfg_data[SPAN_W-1:0];
        CFG_SAMPLE_COUNT: sample_count        <= cfg_data[COUNT_W-1:0];
        CFG_WEIGHT_BOUND: weight_and_boundary <= cfg_data[WAB_W-1:0];
        default: ;
      endcase
    end
  end

  // step is redone after every register write
  assign x_len = span_len(region_x_span);
  assign y_len = span_len(region_y_span);
  assign area  = AREA_W'(x_len) * AREA_W'(y_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pending <= 1'b0;
    end else begin
      start_pending <= cfg_write;
    end
  end

  scpd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (start_pending),
    .dividend (area),
    .divisor  (sample_count),
    .busy     (div_busy),
    .quotient (sample_step)
  );

  // colour error pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hue_r       <= pixel_hue;
      sat_r       <= pixel_sat;
      val_r       <= pixel_val;
      row_end_r   <= row_end;
      frame_end_r <= frame_end;
    end
    hue_sq   <= sq_diff(target_color[23:16], hue_r);
    sat_sq   <= sq_diff(target_color[15:8], sat_r);
    val_sq   <= sq_diff(target_color[7:0], val_r);
    hue_prod <= PROD_W'(hue_factor) * PROD_W'(hue_sq);
    sat_prod <= PROD_W'(sat_factor) * PROD_W'(sat_sq);
    val_prod <= PROD_W'(val_factor) * PROD_W'(val_sq);
    match    <= err_sum <= ERR_LIMIT;
  end

  assign err_sum = ERR_W'(hue_prod) + ERR_W'(sat_prod) + ERR_W'(val_prod);

  assign weight    = weight_and_boundary[WAB_W-1:BOUND_W];
  assign boundary  = weight_and_boundary[BOUND_W-1:0];
  assign in_region = column_counter >= region_x_span[COORD_W-1:0] &&
                     column_counter <  region_x_span[SPAN_W-1:COORD_W] &&
                     row_counter    >= region_y_span[COORD_W-1:0] &&
                     row_counter    <  region_y_span[SPAN_W-1:COORD_W];
  assign left      = sample_count - samples_seen;
  assign reach     = BOUND_W'(left) * BOUND_W'(weight);

  // per-frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter     <= '0;
      row_counter        <= '0;
      region_offset      <= '0;
      next_sample_offset <= '0;
      samples_seen       <= '0;
      weight_sum         <= '0;
      decided_flag       <= 1'b0;
    end else if (cmd.finish && frame_end_r) begin
      column_counter     <= '0;
      row_counter        <= '0;
      region_offset      <= '0;
      next_sample_offset <= '0;
      samples_seen       <= '0;
      weight_sum         <= '0;
      decided_flag       <= 1'b0;
    end else begin
      if (cmd.step) begin
        samples_seen       <= samples_seen + 1'b1;
        next_sample_offset <= next_sample_offset + sample_step;
        weight_sum         <= weight_sum + (match ? BOUND_W'(weight) : '0);
      end
      if (cmd.emit) begin
        decided_flag <= 1'b1;
      end
      if (cmd.finish) begin
        if (in_region) begin
          region_offset <= region_offset + 1'b1;
        end
        if (row_end_r) begin
          column_counter <= '0;
          row_counter    <= row_counter + 1'b1;
        end else begin
          column_counter <= column_counter + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_is_color <= cmd.emit_value;
      res_weight   <= weight_sum;
    end
  end

  assign status.div_busy   = cfg_write | start_pending | div_busy;
  assign status.sample_due = in_region && !decided_flag && samples_seen < sample_count &&
                             next_sample_offset == region_offset;
  assign status.hit        = boundary <= weight_sum;
  assign status.miss       = reach < (boundary - weight_sum);
  assign status.out_full   = res_valid && !res_ready;
  assign status.decided    = decided_flag;
  assign status.frame_end  = frame_end_r;

endmodule

`default_nettype wire

>>> hw/rtl/scpd_ctrl.sv
// controller state machine: sequences one pixel beat through the datapath
// depends on scpd_pkg
`default_nettype none

module scpd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire scpd_pkg::scpd_status_t status,
  output scpd_pkg::scpd_cmd_t         cmd
);
  import scpd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_MULT   = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_STEP   = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = !status.div_busy;
        if (in_valid && !status.div_busy) begin
          cmd.load   = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: state_next = S_MULT;
      S_MULT:   state_next = S_SUM;
      S_SUM:    state_next = S_CHECK;
      S_CHECK: begin
        state_next = status.sample_due ? S_STEP : S_FINISH;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.hit || status.miss) begin
          if (!status.out_full) begin
            cmd.emit       = 1'b1;
            cmd.emit_value = status.hit;
            state_next     = S_FINISH;
          end
        end else begin
          state_next = S_CHECK;
        end
      end
      S_FINISH: begin
        if (status.frame_end && !status.decided) begin
          if (!status.out_full) begin
            cmd.emit   = 1'b1;
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/sparse_color_presence_detector.sv
// sparse colour presence detector: top level joining controller and datapath
// a pixel beat is loaded in idle, then passes the square, multiply, sum and check states;
// each due sample point adds step and decide, an open one going back to check; a result is
// loaded in decide or at an undecided frame end, once the result register is not full
// a register write re-derives the step bit-serially while pixels wait; count 0 gives step 0
// rst is synchronous: registers take their reset values, frame state clears, step is zero
`default_nettype none

module sparse_color_presence_detector #(
  parameter int unsigned FACTOR_FRACTION_BITS = scpd_pkg::DEF_FACTOR_FRACTION_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [scpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [scpd_pkg::CFG_DATA_W-1:0]  cfg_data,
  scpd_pixel_if.sink                            pixels,
  scpd_result_if.source                         results
);
  import scpd_pkg::*;

  scpd_cmd_t    cmd;
  scpd_status_t status;
  logic         in_ready;

  assign pixels.ready = in_ready;

  scpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  scpd_datapath #(
    .FACTOR_FRACTION_BITS (FACTOR_FRACTION_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_hue    (pixels.pixel_hue),
    .pixel_sat    (pixels.pixel_sat),
    .pixel_val    (pixels.pixel_val),
    .row_end      (pixels.row_end),
    .frame_end    (pixels.frame_end),
    .cmd          (cmd),
    .status       (status),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_is_color (results.is_color),
    .res_weight   (results.matched_weight)
  );

endmodule

`default_nettype wire
